### hdl/sss_pkg.sv
// Shared types and constants for the sorted set search/insert block.
// No dependencies; every other file but sss_ram imports this package.
`default_nettype none
package sss_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 9;
  localparam int KEY_W    = 16;

  localparam logic CMD_SEEK   = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_DECIDE,
    S_SHIFT,
    S_FINISH
  } sss_state_t;

  typedef struct packed {
    logic load;
    logic probe;
    logic compare;
    logic shift_init;
    logic shift_step;
    logic finish;
  } sss_cmd_t;

  typedef struct packed {
    logic search_open;
    logic need_shift;
    logic ptr_above;
    logic pend;
    logic out_free;
  } sss_status_t;

endpackage
`default_nettype wire

### hdl/sss_if.sv
// Valid/ready channel interfaces for input and result words.
// Depends on sss_pkg for field widths.
`default_nettype none
interface sss_in_if;
  import sss_pkg::*;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [KEY_W-1:0] value;
  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface sss_out_if;
  import sss_pkg::*;
  logic             valid;
  logic             ready;
  logic             found;
  logic [CNT_W-1:0] position;
  logic             inserted;
  logic             full_res;
  logic [CNT_W-1:0] entries;
  modport source (output valid, output found, output position, output inserted,
                  output full_res, output entries, input ready);
  modport sink   (input valid, input found, input position, input inserted,
                  input full_res, input entries, output ready);
endinterface
`default_nettype wire

### hdl/sss_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module sss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### hdl/sss_ctrl.sv
// Sequencer for search, shift and result hand-off.
// Depends on sss_pkg; drives commands into sss_dp.
`default_nettype none
module sss_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire sss_pkg::sss_status_t status_i,
  output sss_pkg::sss_cmd_t        cmd_o
);
  import sss_pkg::*;

  sss_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_PROBE;
      end
      S_PROBE: begin
        state_nxt = status_i.search_open ? S_CMP : S_DECIDE;
      end
      S_CMP: begin
        state_nxt = S_PROBE;
      end
      S_DECIDE: begin
        state_nxt = status_i.need_shift ? S_SHIFT : S_FINISH;
      end
      S_SHIFT: begin
        if (!status_i.ptr_above && !status_i.pend) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (status_i.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o    = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd_o.load = in_valid;
      end
      S_PROBE:  cmd_o.probe      = status_i.search_open;
      S_CMP:    cmd_o.compare    = 1'b1;
      S_DECIDE: cmd_o.shift_init = status_i.need_shift;
      S_SHIFT:  cmd_o.shift_step = 1'b1;
      S_FINISH: cmd_o.finish     = status_i.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### hdl/sss_dp.sv
// Datapath: search bounds, shift pointer, entry count, table RAM, result register.
// Depends on sss_pkg, sss_if and sss_ram.
`default_nettype none
module sss_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  sss_in_if.sink                 in_ch,
  sss_out_if.source              out_ch,
  input  wire sss_pkg::sss_cmd_t cmd_i,
  output sss_pkg::sss_status_t   status_o
);
  import sss_pkg::*;

  logic             cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [CNT_W-1:0] lo_r, hi_r, mid_r, ptr_r, count_r;
  logic [IDX_W-1:0] pend_addr_r;
  logic             pend_r, eq_r, ins_r;

  logic             out_valid_r, out_found_r, out_inserted_r, out_full_r;
  logic [CNT_W-1:0] out_position_r, out_entries_r;

  logic [CNT_W-1:0] mid_nxt, ptr_dec;
  logic             ptr_above, is_full;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic [KEY_W-1:0] wr_data, rd_data;

  assign mid_nxt   = lo_r + ((hi_r - lo_r) >> 1);
  assign ptr_dec   = ptr_r - CNT_W'(1);
  assign ptr_above = ptr_r > lo_r;
  assign is_full   = count_r >= CNT_W'(CAPACITY);

  assign status_o.search_open = lo_r < hi_r;
  assign status_o.need_shift  = (cmd_r == CMD_INSERT) && !eq_r && !is_full;
  assign status_o.ptr_above   = ptr_above;
  assign status_o.pend        = pend_r;
  assign status_o.out_free    = !out_valid_r || out_ch.ready;

  always_comb begin
    rd_addr = cmd_i.probe ? mid_nxt[IDX_W-1:0] : ptr_dec[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = pend_addr_r;
    wr_data = rd_data;
    if (cmd_i.shift_step) begin
      if (pend_r) begin
        wr_en = 1'b1;
      end else if (!ptr_above) begin
        wr_en   = 1'b1;
        wr_addr = lo_r[IDX_W-1:0];
        wr_data = key_r;
      end
    end
  end

  sss_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_i.shift_init) pend_r <= 1'b0;
      if (cmd_i.shift_step) begin
        pend_r <= ptr_above;
        if (!pend_r && !ptr_above) count_r <= count_r + CNT_W'(1);
      end
      if (cmd_i.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      cmd_r <= in_ch.cmd;
      key_r <= in_ch.value;
      lo_r  <= '0;
      hi_r  <= count_r;
      eq_r  <= 1'b0;
      ins_r <= 1'b0;
    end
    if (cmd_i.probe) mid_r <= mid_nxt;
    if (cmd_i.compare) begin
      if (rd_data < key_r) begin
        lo_r <= mid_r + CNT_W'(1);
      end else begin
        hi_r <= mid_r;
        eq_r <= rd_data == key_r;
      end
    end
    if (cmd_i.shift_init) ptr_r <= count_r;
    if (cmd_i.shift_step) begin
      if (ptr_above) begin
        pend_addr_r <= ptr_r[IDX_W-1:0];
        ptr_r       <= ptr_dec;
      end else if (!pend_r) begin
        ins_r <= 1'b1;
      end
    end
    if (cmd_i.finish) begin
      out_found_r    <= eq_r;
      out_position_r <= lo_r;
      out_inserted_r <= ins_r;
      out_full_r     <= (cmd_r == CMD_INSERT) && !eq_r && !ins_r && is_full;
      out_entries_r  <= count_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.found    = out_found_r;
  assign out_ch.position = out_position_r;
  assign out_ch.inserted = out_inserted_r;
  assign out_ch.full_res = out_full_r;
  assign out_ch.entries  = out_entries_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("entry count moved by other than one");

  a_no_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.probe || cmd_i.compare) |-> !wr_en)
    else $error("table written during search");

  a_insert_absent: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.finish |-> !(ins_r && eq_r))
    else $error("insert of a present value");
`endif

endmodule
`default_nettype wire

### hdl/sorted_set_search_insert.sv
// Top level of the sorted set search/insert block.
// Depends on sss_pkg, sss_if, sss_ctrl and sss_dp.
//
// in_ch carries one word per item: cmd (seek or insert) and a 16-bit value.
// out_ch returns one word per item: found, position (match index or insertion
// point), inserted, full_res and the entry count after the item.
// An item is taken only while the sequencer is idle; a search makes one probe
// of the table RAM per S_PROBE/S_CMP pair plus a closing bound check in
// S_PROBE. An insert of an absent value into a table that is not full then
// moves every higher entry up by one through the RAM's single write port, one
// entry per cycle, then drains the last pending move and stores the new value;
// when the value lands past the last entry only the store is made.
// The block is ready for the next item in the same cycle that the result turns
// valid.
// The result sits in an output register, so a new item is accepted while the
// previous result still waits; a stalled receiver holds the block only when
// the next result is ready to be loaded.
// Reset (rst_n low, synchronous) empties the table by clearing the count and
// drops any pending result; the RAM contents need no clearing.
`default_nettype none
module sorted_set_search_insert (
  input  wire logic clk,
  input  wire logic rst_n,
  sss_in_if.sink    in_ch,
  sss_out_if.source out_ch
);
  import sss_pkg::*;

  sss_cmd_t    cmd;
  sss_status_t status;

  sss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status_i (status),
    .cmd_o    (cmd)
  );

  sss_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cmd_i    (cmd),
    .status_o (status)
  );

endmodule
`default_nettype wire

### tb/sv/tb_sorted_set_search_insert.sv
// Testbench for sorted_set_search_insert: seek and insert words checked against
// a behavioral copy of the sorted table, with random sender gaps and receiver stalls.
// Depends on sss_pkg, sss_if and the block's RTL.
module tb_sorted_set_search_insert;
  import sss_pkg::*;

  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int DRAIN_CYCLES     = 300;
  localparam int FULL_PHASE_ITEMS = 400;
  localparam int MAX_REPORTS      = 10;

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] position;
    logic             inserted;
    logic             full_res;
    logic [CNT_W-1:0] entries;
  } set_result_t;

  logic clk = 1'b0;
  logic rst_n;

  sss_in_if  in_ch ();
  sss_out_if out_ch ();

  sorted_set_search_insert dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  logic [KEY_W-1:0] stored_keys [CAPACITY];
  int               stored_count = 0;
  set_result_t      pending_results [$];

  int burst_left    = 0;
  int idle_cycles   = 0;
  int mismatches    = 0;
  int words_checked = 0;
  int n_seek        = 0;
  int n_insert      = 0;
  int n_stored      = 0;
  int n_hits        = 0;
  int n_refused     = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int lower_bound(input logic [KEY_W-1:0] key);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = stored_count;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (stored_keys[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic bit key_stored(input logic [KEY_W-1:0] key);
    int pos;
    pos = lower_bound(key);
    return (pos < stored_count) && (stored_keys[pos] == key);
  endfunction

  function automatic set_result_t apply_to_set(input logic cmd, input logic [KEY_W-1:0] key);
    int          pos;
    bit          hit;
    set_result_t r;
    pos = lower_bound(key);
    hit = key_stored(key);
    r = '0;
    r.found = hit;
    r.position = CNT_W'(pos);
    if (cmd == CMD_INSERT && !hit) begin
      if (stored_count >= CAPACITY) begin
        r.full_res = 1'b1;
      end else begin
        for (int i = stored_count; i > pos; i--) stored_keys[i] = stored_keys[i - 1];
        stored_keys[pos] = key;
        stored_count++;
        r.inserted = 1'b1;
      end
    end
    r.entries = CNT_W'(stored_count);
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_value();
    logic [KEY_W-1:0] base;
    int               mode;
    mode = $urandom_range(0, 9);
    if (stored_count == 0 || mode >= 6) return KEY_W'($urandom);
    base = stored_keys[$urandom_range(0, stored_count - 1)];
    if (mode < 3) return base;
    if (mode == 3) return base + 1'b1;
    if (mode == 4) return base - 1'b1;
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h7FFF;
      default: return 16'h8000;
    endcase
  endfunction

  task automatic send_word(input logic cmd, input logic [KEY_W-1:0] key);
    set_result_t want;
    int          gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= cmd;
    in_ch.value <= key;
    @(posedge clk);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
    burst_left--;
    want = apply_to_set(cmd, key);
    pending_results.push_back(want);
    if (cmd == CMD_SEEK) n_seek++;
    else n_insert++;
    n_stored  += want.inserted;
    n_hits    += want.found;
    n_refused += want.full_res;
  endtask

  task automatic test_small_table();
    send_word(CMD_SEEK,   16'h0000);
    send_word(CMD_SEEK,   16'hFFFF);
    send_word(CMD_INSERT, 16'h8000);
    send_word(CMD_INSERT, 16'h8000);
    send_word(CMD_INSERT, 16'h0000);
    send_word(CMD_INSERT, 16'hFFFE);
    send_word(CMD_INSERT, 16'h4000);
    send_word(CMD_INSERT, 16'hC000);
    send_word(CMD_SEEK,   16'h4000);
    send_word(CMD_SEEK,   16'h4001);
    send_word(CMD_SEEK,   16'hFFFF);
    send_word(CMD_SEEK,   16'h0000);
    send_word(CMD_INSERT, 16'h0001);
    send_word(CMD_SEEK,   16'h7FFF);
    send_word(CMD_INSERT, 16'h8001);
  endtask

  task automatic test_fill_random();
    logic [KEY_W-1:0] key;
    while (stored_count < CAPACITY) begin
      if ($urandom_range(0, 4) == 0) begin
        send_word(CMD_SEEK, pick_value());
      end else begin
        key = ($urandom_range(0, 3) == 0) ? pick_value() : KEY_W'($urandom);
        // keep the top key free so a full table still has a point past its end
        if (key == 16'hFFFF) key = 16'hFFFE;
        send_word(CMD_INSERT, key);
      end
    end
  endtask

  task automatic test_full_table();
    logic [KEY_W-1:0] key;
    send_word(CMD_SEEK,   16'hFFFF);
    send_word(CMD_INSERT, 16'hFFFF);
    key = KEY_W'($urandom);
    while (key_stored(key)) key = KEY_W'($urandom);
    send_word(CMD_INSERT, key);
    send_word(CMD_INSERT, stored_keys[$urandom_range(0, CAPACITY - 1)]);
    send_word(CMD_INSERT, stored_keys[0]);
    send_word(CMD_SEEK,   stored_keys[CAPACITY - 1]);
    send_word(CMD_SEEK,   key);
  endtask

  task automatic test_random_on_full();
    repeat (FULL_PHASE_ITEMS) begin
      send_word(($urandom_range(0, 1) == 1) ? CMD_INSERT : CMD_SEEK, pick_value());
    end
  endtask

  initial begin : result_sink
    logic [15:0] stall_pat;
    int          reload_cnt;
    set_result_t got;
    set_result_t want;
    stall_pat  = 16'hFFFF;
    reload_cnt = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.found    = out_ch.found;
        got.position = out_ch.position;
        got.inserted = out_ch.inserted;
        got.full_res = out_ch.full_res;
        got.entries  = out_ch.entries;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected word found=%0b pos=%0d ins=%0b full=%0b entries=%0d",
                     $realtime, got.found, got.position, got.inserted, got.full_res,
                     got.entries);
        end else begin
          want = pending_results.pop_front();
          words_checked++;
          if (got.found !== want.found || got.position !== want.position ||
              got.inserted !== want.inserted || got.full_res !== want.full_res ||
              got.entries !== want.entries) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: word %0d expected found=%0b pos=%0d ins=%0b full=%0b entries=%0d, got found=%0b pos=%0d ins=%0b full=%0b entries=%0d",
                       $realtime, words_checked, want.found, want.position, want.inserted,
                       want.full_res, want.entries, got.found, got.position, got.inserted,
                       got.full_res, got.entries);
          end
        end
      end
      reload_cnt++;
      if (reload_cnt == 64) begin
        reload_cnt = 0;
        case ($urandom_range(0, 3))
          0: stall_pat = 16'hFFFF;
          1: stall_pat = 16'($urandom);
          2: stall_pat = 16'($urandom | $urandom);
          default: stall_pat = 16'($urandom & $urandom);
        endcase
        stall_pat[0] = 1'b1;
      end
      out_ch.ready <= stall_pat[15];
      stall_pat = {stall_pat[14:0], stall_pat[15]};
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.cmd   <= CMD_SEEK;
    in_ch.value <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_small_table();
    test_fill_random();
    test_full_table();
    test_random_on_full();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d items (%0d seeks, %0d inserts), checked %0d result words",
             n_seek + n_insert, n_seek, n_insert, words_checked);
    $display("%0d keys stored, %0d hits, %0d inserts refused on a full table, final count %0d of %0d",
             n_stored, n_hits, n_refused, stored_count, CAPACITY);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
